// ===== sv/ufcc_pkg.sv =====
// ----------------------------------------------------------------------------
// ufcc_pkg
// Shared widths, types and constants of the union-find component counter.
// ----------------------------------------------------------------------------
package ufcc_pkg;

    localparam int NODES   = 1024;
    localparam int ID_W    = $clog2(NODES);
    localparam int CNT_W   = ID_W + 1;
    localparam int EDGE_W  = 32;
    localparam int QDEPTH  = 2;

    localparam logic MODE_EDGE   = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic            report;
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
    } cmd_t;

    // Clear request from the configuration port.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nodes;
    } clr_t;

endpackage

// ===== sv/ufcc_front.sv =====
// ----------------------------------------------------------------------------
// ufcc_front
// Accepts input items, drops out-of-range edges and queues commands.
// ----------------------------------------------------------------------------
module ufcc_front
    import ufcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             ready,
    input  logic             mode,
    input  logic [ID_W-1:0]  node_a,
    input  logic [ID_W-1:0]  node_b,
    input  logic [CNT_W-1:0] eff_nodes,
    input  logic             flush,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output cmd_t             cmd
);

    cmd_t        q_mem [QDEPTH];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        push, pop, keep;

    assign ready     = (fill_reg != 2'(QDEPTH)) && !flush;
    assign keep      = (mode == MODE_REPORT) ||
                       ((CNT_W'(node_a) < eff_nodes) && (CNT_W'(node_b) < eff_nodes));
    assign push      = valid && ready && keep;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{report: mode, node_a: node_a, node_b: node_b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== sv/ufcc_back.sv =====
// ----------------------------------------------------------------------------
// ufcc_back
// Root walks with path compression, union by size, report and clear sweep.
// ----------------------------------------------------------------------------
module ufcc_back
    import ufcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  clr_t             clr,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output logic [CNT_W-1:0] res_ops,
    output logic [CNT_W-1:0] res_comp,
    output logic             res_short
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FRD, S_FWAIT, S_FCHK, S_CRD, S_CWAIT, S_CWR,
        S_SZRD, S_SZWAIT, S_MERGE
    } state_t;

    logic [ID_W-1:0]  parent_mem [NODES];
    logic [CNT_W-1:0] size_mem   [NODES];

    state_t           state_reg;
    logic [ID_W-1:0]  addr_reg, clr_idx_reg, root_reg, start_reg;
    logic [ID_W-1:0]  nb_reg, ra_reg, szra_idx_reg;
    logic [ID_W:0]    steps_reg;
    logic             second_reg, report_pend_reg;
    logic [ID_W-1:0]  p_rd_reg;
    logic [CNT_W-1:0] s_rd_reg, sa_reg;
    logic [EDGE_W-1:0] edges_reg;
    logic [CNT_W-1:0] comp_reg, nodes_reg;
    logic             rv_reg;
    logic [CNT_W-1:0] ops_reg, rc_reg;
    logic             rs_reg;

    logic             p_we, s_we;
    logic [ID_W-1:0]  p_wa, s_wa, p_ra, s_ra;
    logic [ID_W-1:0]  p_wd;
    logic [CNT_W-1:0] s_wd;

    always_ff @(posedge clk)
    begin
        if (p_we)
            parent_mem[p_wa] <= p_wd;
        if (s_we)
            size_mem[s_wa] <= s_wd;
        p_rd_reg <= parent_mem[p_ra];
        s_rd_reg <= size_mem[s_ra];
    end

    // memory port steering
    always_comb
    begin
        p_we = 1'b0;
        s_we = 1'b0;
        p_wa = addr_reg;
        s_wa = addr_reg;
        p_wd = root_reg;
        s_wd = sa_reg + s_rd_reg;
        p_ra = addr_reg;
        s_ra = ra_reg;
        case (state_reg)
            S_CLEAR:
            begin
                p_we = 1'b1;
                s_we = 1'b1;
                p_wa = clr_idx_reg;
                s_wa = clr_idx_reg;
                p_wd = clr_idx_reg;
                s_wd = CNT_W'(1);
            end
            S_CWR:
            begin
                p_we = (addr_reg != root_reg);
            end
            S_SZRD:
            begin
                s_ra = ra_reg;
            end
            S_SZWAIT:
            begin
                s_ra = root_reg;
            end
            S_MERGE:
            begin
                // s_rd_reg holds size of root b, sa_reg size of root a
                p_we = 1'b1;
                s_we = 1'b1;
                if (sa_reg < s_rd_reg)
                begin
                    p_wa = ra_reg;
                    p_wd = root_reg;
                    s_wa = root_reg;
                end
                else
                begin
                    p_wa = root_reg;
                    p_wd = ra_reg;
                    s_wa = ra_reg;
                end
            end
            default: ;
        endcase
    end

    assign cmd_ready = (state_reg == S_IDLE) && !clr.start &&
                       !(cmd.report && rv_reg && !res_ready);
    assign res_valid = rv_reg;
    assign res_ops   = ops_reg;
    assign res_comp  = rc_reg;
    assign res_short = rs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            edges_reg       <= '0;
            nodes_reg       <= CNT_W'(NODES);
            comp_reg        <= CNT_W'(NODES);
            rv_reg          <= 1'b0;
            second_reg      <= 1'b0;
            report_pend_reg <= 1'b0;
            steps_reg       <= '0;
        end
        else
        begin
            if (rv_reg && res_ready)
                rv_reg <= 1'b0;
            if (clr.start)
            begin
                nodes_reg   <= clr.nodes;
                comp_reg    <= clr.nodes;
                edges_reg   <= '0;
                clr_idx_reg <= '0;
                state_reg   <= S_CLEAR;
            end
            else
            begin
                case (state_reg)
                    S_CLEAR:
                    begin
                        clr_idx_reg <= clr_idx_reg + 1'b1;
                        if (clr_idx_reg == ID_W'(NODES - 1))
                            state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (cmd_valid && cmd_ready)
                        begin
                            if (cmd.report)
                            begin
                                rv_reg <= 1'b1;
                                rs_reg <= (EDGE_W'(nodes_reg) - EDGE_W'(1)) > edges_reg;
                                ops_reg <= ((EDGE_W'(nodes_reg) - EDGE_W'(1)) > edges_reg)
                                           ? '1 : comp_reg - 1'b1;
                                rc_reg <= comp_reg;
                                comp_reg    <= nodes_reg;
                                edges_reg   <= '0;
                                clr_idx_reg <= '0;
                                state_reg   <= S_CLEAR;
                            end
                            else
                            begin
                                if (edges_reg != '1)
                                    edges_reg <= edges_reg + 1'b1;
                                addr_reg   <= cmd.node_a;
                                start_reg  <= cmd.node_a;
                                nb_reg     <= cmd.node_b;
                                second_reg <= 1'b0;
                                steps_reg  <= '0;
                                state_reg  <= S_FRD;
                            end
                        end
                    end
                    S_FRD:
                        state_reg <= S_FWAIT;
                    S_FWAIT:
                        state_reg <= S_FCHK;
                    S_FCHK:
                    begin
                        // p_rd_reg is parent of addr_reg
                        if (p_rd_reg == addr_reg ||
                            steps_reg == (ID_W+1)'(NODES))
                        begin
                            root_reg  <= addr_reg;
                            addr_reg  <= start_reg;
                            steps_reg <= '0;
                            state_reg <= S_CRD;
                        end
                        else
                        begin
                            addr_reg  <= p_rd_reg;
                            steps_reg <= steps_reg + 1'b1;
                            state_reg <= S_FWAIT;
                        end
                    end
                    S_CRD:
                    begin
                        if (addr_reg == root_reg ||
                            steps_reg == (ID_W+1)'(NODES))
                        begin
                            if (!second_reg)
                            begin
                                ra_reg     <= root_reg;
                                second_reg <= 1'b1;
                                addr_reg   <= nb_reg;
                                start_reg  <= nb_reg;
                                steps_reg  <= '0;
                                state_reg  <= S_FRD;
                            end
                            else if (ra_reg == root_reg)
                                state_reg <= S_IDLE;
                            else
                                state_reg <= S_SZRD;
                        end
                        else
                            state_reg <= S_CWAIT;
                    end
                    S_CWAIT:
                        state_reg <= S_CWR;
                    S_CWR:
                    begin
                        addr_reg  <= p_rd_reg;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                    S_SZRD:
                        state_reg <= S_SZWAIT;
                    S_SZWAIT:
                    begin
                        sa_reg    <= s_rd_reg;
                        state_reg <= S_MERGE;
                    end
                    S_MERGE:
                    begin
                        if (comp_reg > CNT_W'(1))
                            comp_reg <= comp_reg - 1'b1;
                        state_reg <= S_IDLE;
                    end
                    default:
                        state_reg <= S_IDLE;
                endcase
            end
        end
    end

endmodule

// ===== sv/union_find_component_counter.sv =====
// ----------------------------------------------------------------------------
// union_find_component_counter
// Disjoint-set engine: union by size, path compression, component report.
// ----------------------------------------------------------------------------
// Input channel (valid/ready) carries mode, node_a, node_b. An edge transfer
// (mode 0) returns nothing; a report transfer (mode 1) returns one result on
// the output channel (valid/ready) and then clears the store.
// Edges with an endpoint at or above node_count are dropped at the front.
// The front queues up to two commands so it keeps taking transfers while the
// back walks parent memory.
// Edge steps: the back takes the command, walks from each endpoint to its
// root (registered memory read each hop), points each node on the path at
// the root, then, if the roots differ, merges them by size.
// Report: the result is registered as the back takes the command, then a
// clear sweep runs over both tables.
// Reset and node_count writes run the same clear sweep; no command enters
// the back meanwhile. A stalled receiver holds the result; a following
// report waits until the result is taken.
// ----------------------------------------------------------------------------
module union_find_component_counter
    import ufcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             mode,
    input  logic [ID_W-1:0]  node_a,
    input  logic [ID_W-1:0]  node_b,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CNT_W-1:0] operations_needed,
    output logic [CNT_W-1:0] component_count,
    output logic             cable_short
);

    logic [CNT_W-1:0] eff_nodes_reg;
    logic [CNT_W-1:0] eff_wr;
    clr_t             clr;
    logic             cmd_valid, cmd_ready;
    cmd_t             cmd;

    // clamp node_count to 1..NODES
    assign eff_wr = (cfg_wdata == '0) ? CNT_W'(1) :
                    (cfg_wdata > CNT_W'(NODES)) ? CNT_W'(NODES) : cfg_wdata;
    assign clr    = '{start: cfg_we, nodes: eff_wr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eff_nodes_reg <= CNT_W'(NODES);
        else if (cfg_we)
            eff_nodes_reg <= eff_wr;
    end

    ufcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .ready     (in_ready),
        .mode      (mode),
        .node_a    (node_a),
        .node_b    (node_b),
        .eff_nodes (eff_nodes_reg),
        .flush     (cfg_we),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ufcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (clr),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res_ops   (operations_needed),
        .res_comp  (component_count),
        .res_short (cable_short)
    );

endmodule

// ===== sv/ufcc_checker.sv =====
// ----------------------------------------------------------------------------
// ufcc_checker
// Port-level checks on the component counter.
// ----------------------------------------------------------------------------
module ufcc_checker
    import ufcc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CNT_W-1:0] operations_needed,
    input logic [CNT_W-1:0] component_count,
    input logic             cable_short
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(operations_needed))
        else $error("result dropped while stalled");

    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cable_short |-> operations_needed == '1)
        else $error("short result must report minus one");

    a_ops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cable_short |-> operations_needed == component_count - 1'b1)
        else $error("operations must be components minus one");

    a_comp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> component_count != '0)
        else $error("zero components reported");

endmodule

bind union_find_component_counter ufcc_checker u_ufcc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .operations_needed (operations_needed),
    .component_count   (component_count),
    .cable_short       (cable_short)
);

// ===== dv/tb_union_find_component_counter.sv =====
// ----------------------------------------------------------------------------
// tb_union_find_component_counter
// Self-checking bench: predicts report results with a local disjoint-set
// model and checks every result transfer, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_union_find_component_counter;
    import ufcc_pkg::*;

    // Worst pause before a register write: two queued edges plus a clear sweep.
    localparam int SETTLE_CYCLES = 3 * NODES;

    typedef struct {
        logic [CNT_W-1:0] ops;
        logic [CNT_W-1:0] comps;
        logic             short_flag;
    } report_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    logic             mode;
    logic [ID_W-1:0]  node_a;
    logic [ID_W-1:0]  node_b;
    logic             out_valid;
    logic             out_ready;
    logic [CNT_W-1:0] operations_needed;
    logic [CNT_W-1:0] component_count;
    logic             cable_short;

    // Local copy of the disjoint-set store.
    int unsigned  graph_nodes;
    int unsigned  root_of[NODES];
    int unsigned  set_size[NODES];
    int unsigned  edges_seen;
    int unsigned  comps_left;
    report_t      pending_reports[$];
    int           mismatches;
    int           items_sent;
    bit           quiet_phase;

    union_find_component_counter u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .node_a            (node_a),
        .node_b            (node_b),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .operations_needed (operations_needed),
        .component_count   (component_count),
        .cable_short       (cable_short)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- model
    function automatic int unsigned active_nodes();
        if (graph_nodes == 0)
            return 1;
        if (graph_nodes > NODES)
            return NODES;
        return graph_nodes;
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < NODES; i++)
        begin
            root_of[i]  = i;
            set_size[i] = 1;
        end
        edges_seen = 0;
        comps_left = active_nodes();
    endfunction

    // Walk to the root, then point every node on the path at it.
    function automatic int unsigned find_and_compress(int unsigned x);
        int unsigned r;
        int unsigned nxt;
        r = x;
        while (root_of[r] != r)
            r = root_of[r];
        while (x != r)
        begin
            nxt        = root_of[x];
            root_of[x] = r;
            x          = nxt;
        end
        return r;
    endfunction

    function automatic void predict_item(logic m, int unsigned a, int unsigned b);
        int unsigned n;
        int unsigned ra;
        int unsigned rb;
        report_t     rep;
        n = active_nodes();
        if (m == MODE_EDGE)
        begin
            // Drop edges that leave the graph.
            if (a >= n || b >= n)
                return;
            if (edges_seen != 32'hFFFF_FFFF)
                edges_seen++;
            ra = find_and_compress(a);
            rb = find_and_compress(b);
            if (ra == rb)
                return;
            // On a tie the second endpoint's root goes under the first.
            if (set_size[ra] < set_size[rb])
            begin
                root_of[ra]   = rb;
                set_size[rb] += set_size[ra];
            end
            else
            begin
                root_of[rb]   = ra;
                set_size[ra] += set_size[rb];
            end
            if (comps_left > 1)
                comps_left--;
        end
        else
        begin
            rep.short_flag = (edges_seen < n - 1);
            rep.ops        = rep.short_flag ? '1 : CNT_W'(comps_left - 1);
            rep.comps      = CNT_W'(comps_left);
            pending_reports.push_back(rep);
            wipe_store();
        end
    endfunction

    // ---------------------------------------------------------------- driving
    // Hold valid and payload until the transfer lands; predict on acceptance.
    task automatic send_item(logic m, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        int  gap;
        bit  taken;
        gap = quiet_phase ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        node_a   <= a;
        node_b   <= b;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        predict_item(m, a, b);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Write node_count only once the block has gone quiet.
    task automatic write_node_count(logic [CNT_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        graph_nodes = value;
        wipe_store();
    endtask

    task automatic send_edge(int unsigned a, int unsigned b);
        send_item(MODE_EDGE, ID_W'(a), ID_W'(b));
    endtask

    task automatic send_report();
        send_item(MODE_REPORT, ID_W'($urandom), ID_W'($urandom));
    endtask

    // ---------------------------------------------------------------- checking
    initial
    begin
        bit      taken;
        int      stall;
        report_t exp_rep;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                taken = out_valid && out_ready;
                @(posedge clk);
            end
            while (!taken);
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ops=%0d comps=%0d short=%0b",
                             $signed(operations_needed), component_count, cable_short);
            end
            else
            begin
                exp_rep = pending_reports.pop_front();
                if (operations_needed !== exp_rep.ops || component_count !== exp_rep.comps
                    || cable_short !== exp_rep.short_flag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ops=%0d comps=%0d short=%0b, ",
                                 $signed(exp_rep.ops), exp_rep.comps, exp_rep.short_flag,
                                 "got ops=%0d comps=%0d short=%0b",
                                 $signed(operations_needed), component_count, cable_short);
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests
    // Report straight after reset: full 1024-node graph, one join and one self loop.
    task automatic test_reset_state();
        send_edge(1023, 0);
        send_edge(1023, 1023);
        send_report();
    endtask

    // Register extremes: zero acts as one node, all ones as the full size.
    task automatic test_size_extremes();
        write_node_count('0);
        send_edge(0, 0);
        send_edge(1, 0);
        send_report();
        write_node_count('1);
        send_edge(1023, 512);
        send_report();
        write_node_count(CNT_W'(1));
        send_report();
    endtask

    // Self loops, repeated joins, ties and dropped endpoints on a small graph.
    task automatic test_edge_cases();
        write_node_count(CNT_W'(5));
        send_edge(0, 1);
        send_edge(2, 3);
        send_edge(0, 0);
        send_edge(1, 0);
        send_edge(4, 5);
        send_edge(1023, 2);
        send_report();
        send_edge(0, 1);
        send_edge(1, 2);
        send_edge(3, 2);
        send_edge(4, 0);
        send_report();
    endtask

    // Well-formed graphs with random content, some noise, frequent reports.
    task automatic test_random_graphs();
        int unsigned n;
        int unsigned k;
        int          groups;
        groups = 0;
        while (items_sent < 950)
        begin
            if (groups % 8 == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       n = 1024;
                    1:       n = $urandom_range(1, 1024);
                    default: n = $urandom_range(2, 24);
                endcase
                write_node_count(CNT_W'(n));
            end
            // Stretches with no idling on either side.
            quiet_phase = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, (n > 20) ? 40 : 2 * n);
            repeat (k)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_edge($urandom_range(0, 1023), $urandom_range(0, 1023));
                else
                    send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
            end
            send_report();
            groups++;
            // Hold off the sender until every result is back.
            if (groups % 10 == 0)
                drain_results();
        end
        quiet_phase = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        mode        = MODE_EDGE;
        node_a      = '0;
        node_b      = '0;
        mismatches  = 0;
        items_sent  = 0;
        quiet_phase = 1'b0;
        graph_nodes = NODES;
        wipe_store();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_size_extremes();
        test_edge_cases();
        test_random_graphs();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
